/* hdl/rcmb_pkg.sv */
// Shared types, codes and a helper function for the RGB565 colour-math blender.
package rcmb_pkg;

    // Blend function codes carried by the func field
    localparam logic [2:0] FUNC_ADD       = 3'd0;
    localparam logic [2:0] FUNC_SUB       = 3'd1;
    localparam logic [2:0] FUNC_HALF_SUB  = 3'd2;
    localparam logic [2:0] FUNC_HALF_ADD  = 3'd3;
    localparam logic [2:0] FUNC_HALF_FIX  = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_MASK  = 2'd1;

    // Register reset values
    localparam logic [15:0] CHANNEL_MASK_RST = 16'hF7DE;
    localparam logic [15:0] MARKER_MASK_RST  = 16'h0020;

    // Configuration registers as seen by the pipeline
    typedef struct packed {
        logic [15:0] channel_mask;
        logic [15:0] marker_mask;
    } cfg_t;

    // Payload after decode: masked operands and skip decision
    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] main_pixel;
        logic [15:0] op_a;
        logic [15:0] op_b;
        logic        skip;
        logic        sub_marked;
    } dec_t;

    // Payload after the halving adder
    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] main_pixel;
        logic [15:0] half;
        logic        skip;
        logic        sub_marked;
    } half_t;

    // Final result item
    typedef struct packed {
        logic [15:0] result_pixel;
        logic        written;
    } res_t;

    // Double each channel of a half-sum and saturate at the channel maximum
    function automatic logic [15:0] dbl_sat(input logic [15:0] h);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        begin
            r = h[15] ? 5'h1F : {h[14:11], 1'b0};
            g = h[10] ? 6'h3F : {h[9:5], 1'b0};
            b = h[4]  ? 5'h1F : {h[3:0], 1'b0};
            return {r, g, b};
        end
    endfunction

endpackage

/* hdl/rcmb_if.sv */
// Channel interfaces: pixel pair input, blended result output, configuration writes.
interface rcmb_pix_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [15:0] main_pixel;
    logic [15:0] sub_pixel;

    modport source (output valid, output func, output main_pixel, output sub_pixel,
                    input ready);
    modport sink (input valid, input func, input main_pixel, input sub_pixel,
                  output ready);
endinterface

interface rcmb_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_pixel;
    logic        written;

    modport source (output valid, output result_pixel, output written, input ready);
    modport sink (input valid, input result_pixel, input written, output ready);
endinterface

interface rcmb_cfg_if;
    import rcmb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/rcmb_decode.sv */
// Stage 1: test markers, pick the skip case and mask both operands.
module rcmb_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic [15:0]        main_pixel,
    input  logic [15:0]        sub_pixel,
    input  rcmb_pkg::cfg_t     cfg_regs,
    output logic               out_valid,
    input  logic               out_ready,
    output rcmb_pkg::dec_t     out_data
);
    import rcmb_pkg::*;

    logic valid_reg;
    dec_t data_reg;
    dec_t data_next;
    logic main_marked;
    logic sub_marked;
    logic is_sub;

    // Decode markers and skip condition
    always_comb
    begin
        main_marked = (main_pixel & cfg_regs.marker_mask) != 16'h0000;
        sub_marked  = (sub_pixel & cfg_regs.marker_mask) != 16'h0000;
        is_sub      = 1'b0;
        data_next.skip = !main_marked;
        case (func)
            FUNC_ADD:      ;
            FUNC_SUB:      is_sub = 1'b1;
            FUNC_HALF_SUB: is_sub = 1'b1;
            FUNC_HALF_ADD: if (sub_marked) data_next.skip = 1'b1;
            FUNC_HALF_FIX: ;
            default:       data_next.skip = 1'b1;
        endcase
        data_next.func       = func;
        data_next.main_pixel = main_pixel;
        data_next.op_a       = (is_sub ? ~main_pixel : main_pixel) & cfg_regs.channel_mask;
        data_next.op_b       = sub_pixel & cfg_regs.channel_mask;
        data_next.sub_marked = sub_marked;
    end

    // Advance when the stage is empty or its content moves on
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hdl/rcmb_halve.sv */
// Stage 2: 17-bit add of the masked operands, shifted down one place.
module rcmb_halve (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rcmb_pkg::dec_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rcmb_pkg::half_t    out_data
);
    import rcmb_pkg::*;

    logic        valid_reg;
    half_t       data_reg;
    half_t       data_next;
    logic [16:0] sum;

    // Form the half-sum; the carry lands in bit 15
    always_comb
    begin
        sum = {1'b0, in_data.op_a} + {1'b0, in_data.op_b};
        data_next.func       = in_data.func;
        data_next.main_pixel = in_data.main_pixel;
        data_next.half       = sum[16:1];
        data_next.skip       = in_data.skip;
        data_next.sub_marked = in_data.sub_marked;
    end

    // Advance when the stage is empty or its content moves on
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hdl/rcmb_finish.sv */
// Stage 3: saturating double, subtract complement, final halving and result select.
module rcmb_finish (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rcmb_pkg::half_t    in_data,
    input  rcmb_pkg::cfg_t     cfg_regs,
    output logic               out_valid,
    input  logic               out_ready,
    output rcmb_pkg::res_t     out_data
);
    import rcmb_pkg::*;

    logic        valid_reg;
    res_t        data_reg;
    res_t        data_next;
    logic [15:0] dbl;
    logic [15:0] inv;

    // Select the blended pixel for the function code
    always_comb
    begin
        dbl = dbl_sat(in_data.half);
        inv = ~dbl;
        data_next.result_pixel = in_data.main_pixel;
        data_next.written      = 1'b0;
        if (!in_data.skip)
        begin
            data_next.written = 1'b1;
            case (in_data.func)
                FUNC_ADD:      data_next.result_pixel = dbl;
                FUNC_SUB:      data_next.result_pixel = inv;
                FUNC_HALF_SUB:
                    if (in_data.sub_marked)
                        data_next.result_pixel = inv;
                    else
                        data_next.result_pixel = (inv & cfg_regs.channel_mask) >> 1;
                FUNC_HALF_ADD: data_next.result_pixel = in_data.half;
                FUNC_HALF_FIX:
                    data_next.result_pixel = in_data.sub_marked ? dbl : in_data.half;
                default:
                begin
                    data_next.result_pixel = in_data.main_pixel;
                    data_next.written      = 1'b0;
                end
            endcase
        end
    end

    // Hold the result until the receiver takes it
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hdl/rgb565_colour_math_blender.sv */
// Top level of the RGB565 colour-math blender: config registers and three-stage pipeline.
//
// Usage:
// - pixels: one transfer carries func, main_pixel and sub_pixel. One item may be
//   taken every cycle.
// - blended: one transfer per input item, in order, carrying result_pixel and
//   written. written is 0 when the main pixel is passed through unchanged.
// - cfg: index 0 writes channel_mask, index 1 writes marker_mask; other indexes
//   are ignored. The port is always ready. Write only while the pipeline is empty.
// Path: each result is registered in the decode, halve and finish stages in turn
//   before it is valid at blended.
// Throughput: 1 item per cycle unless blended stalls; set by the three register stages
//   (decode/mask, halving adder, double/select) each taking one item per cycle.
// Reset: rst_n clears all stage valid bits and loads channel_mask = 0xF7DE and
//   marker_mask = 0x0020; no result is pending afterward.
// Stall: when blended.ready is low, the last stage holds its result and empty
//   stages ahead of it keep filling; once all three stages are full, pixels.ready
//   drops in the same cycle, so up to three items are held without loss or repetition.
module rgb565_colour_math_blender (
    input  logic          clk,
    input  logic          rst_n,
    rcmb_pix_if.sink      pixels,
    rcmb_res_if.source    blended,
    rcmb_cfg_if.sink      cfg
);
    import rcmb_pkg::*;

    logic [15:0] channel_mask_reg;
    logic [15:0] marker_mask_reg;
    cfg_t        cfg_regs;

    logic        dec_valid;
    logic        dec_ready;
    dec_t        dec_data;
    logic        half_valid;
    logic        half_ready;
    half_t       half_data;
    res_t        res_data;

    // Accept configuration writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_mask_reg <= CHANNEL_MASK_RST;
            marker_mask_reg  <= MARKER_MASK_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CHANNEL_MASK: channel_mask_reg <= cfg.data;
                CFG_MARKER_MASK:  marker_mask_reg  <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign cfg_regs.channel_mask = channel_mask_reg;
    assign cfg_regs.marker_mask  = marker_mask_reg;

    // Stage 1: decode and mask
    rcmb_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pixels.valid),
        .in_ready   (pixels.ready),
        .func       (pixels.func),
        .main_pixel (pixels.main_pixel),
        .sub_pixel  (pixels.sub_pixel),
        .cfg_regs   (cfg_regs),
        .out_valid  (dec_valid),
        .out_ready  (dec_ready),
        .out_data   (dec_data)
    );

    // Stage 2: halving adder
    rcmb_halve u_halve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (half_valid),
        .out_ready (half_ready),
        .out_data  (half_data)
    );

    // Stage 3: double, complement and select
    rcmb_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (half_valid),
        .in_ready  (half_ready),
        .in_data   (half_data),
        .cfg_regs  (cfg_regs),
        .out_valid (blended.valid),
        .out_ready (blended.ready),
        .out_data  (res_data)
    );

    assign blended.result_pixel = res_data.result_pixel;
    assign blended.written      = res_data.written;

endmodule
